FILE: rtl/core/c2s_pkg.sv
// Shared constants and the arctangent table for the Cartesian-to-spherical pipeline.
package c2s_pkg;

  localparam int unsigned COORD_WIDTH_DEF  = 16;
  localparam int unsigned CORDIC_STEPS_DEF = 18;

  // coordinates are scaled up by this many bits before the CORDIC runs
  localparam int unsigned GUARD_BITS = 16;

  // binary angle: 2^32 per turn, signed, wide enough for +/-180 deg plus residue
  localparam int unsigned ANG_W = 33;
  localparam int unsigned MAG_W = ANG_W - 1;
  localparam int unsigned ATAN_W = 32;
  localparam int unsigned ATAN_DEPTH = 32;

  localparam logic signed [ANG_W-1:0] HALF_TURN     = {2'b01, 31'd0};
  localparam logic signed [ANG_W-1:0] NEG_HALF_TURN = {2'b11, 31'd0};

  // CORDIC gain in Q30; z is pre-scaled by it for the polar rotation
  localparam int unsigned GAIN_W = 32;
  localparam logic signed [GAIN_W-1:0] GAIN_Q30 = 32'sd1768195363;
  localparam int unsigned GAIN_SHIFT = 30 - GUARD_BITS;

  // binary angle to 1/128 degree: * 360*128, round, >> 32
  localparam int unsigned DEG_SCALE_W = 16;
  localparam logic [DEG_SCALE_W-1:0] DEG_SCALE = 16'd46080;
  localparam int unsigned PROD_W = MAG_W + DEG_SCALE_W;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(64'h8000_0000);
  localparam int unsigned ANGLE_Q_W = PROD_W - 32;
  localparam logic [ANGLE_Q_W-1:0] ANGLE_LIMIT = 16'd23040;

  // result fields
  localparam int unsigned RADIUS_W = 16;
  localparam int unsigned POLAR_W  = 15;
  localparam int unsigned AZIM_W   = 16;
  localparam logic [RADIUS_W-1:0] RADIUS_MAX = '1;
  localparam int unsigned OUT_FIELDS_W = RADIUS_W + POLAR_W + AZIM_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  // atan(2^-i) in binary angle units
  localparam logic [ATAN_W-1:0] ATAN_TABLE [ATAN_DEPTH] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

endpackage

FILE: rtl/core/c2s_pipe_reg.sv
// Elastic pipeline register: holds one request, advances whenever downstream has room.
module c2s_pipe_reg #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [WIDTH-1:0] data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [WIDTH-1:0] data_o
);

  logic             valid_q;
  logic [WIDTH-1:0] data_q;

  // a bubble here can always be filled, even while downstream stalls
  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/core/c2s_sqrt_stage.sv
// One digit of the restoring integer square root, registered.
module c2s_sqrt_stage #(
  parameter int unsigned CW     = 16,
  parameter int unsigned DIGIT  = 0,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [2*CW-1:0]   rem_i,
  input  logic [CW-1:0]     root_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [2*CW-1:0]   rem_o,
  output logic [CW-1:0]     root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned TW     = 2 * CW + 1;
  localparam int unsigned DATA_W = 2 * CW + CW + SIDE_W;

  logic [TW-1:0]     rem_ext;
  logic [TW-1:0]     trial;
  logic [TW-1:0]     rem_sub;
  logic              take;
  logic [2*CW-1:0]   rem_d;
  logic [CW-1:0]     root_d;
  logic [DATA_W-1:0] data_out;

  // (root + 2^k)^2 - root^2 = root*2^(k+1) + 2^(2k)
  assign rem_ext = {1'b0, rem_i};
  assign trial   = ({{(CW + 1){1'b0}}, root_i} << (DIGIT + 1)) + (TW'(1) << (2 * DIGIT));
  assign take    = rem_ext >= trial;
  assign rem_sub = rem_ext - trial;
  assign rem_d   = take ? rem_sub[2*CW-1:0] : rem_i;
  assign root_d  = take ? (root_i | (CW'(1) << DIGIT)) : root_i;

  c2s_pipe_reg #(
    .WIDTH(DATA_W)
  ) u_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(valid_i),
    .ready_o(ready_o),
    .data_i ({rem_d, root_d, side_i}),
    .valid_o(valid_o),
    .ready_i(ready_i),
    .data_o (data_out)
  );

  assign {rem_o, root_o, side_o} = data_out;

endmodule

FILE: rtl/core/c2s_cordic_stage.sv
// One CORDIC vectoring micro-rotation, registered.
module c2s_cordic_stage
  import c2s_pkg::*;
#(
  parameter int unsigned DW     = 35,
  parameter int unsigned STEP   = 0,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic signed [DW-1:0]    x_i,
  input  logic signed [DW-1:0]    y_i,
  input  logic signed [ANG_W-1:0] ang_i,
  input  logic [SIDE_W-1:0]       side_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic signed [DW-1:0]    x_o,
  output logic signed [DW-1:0]    y_o,
  output logic signed [ANG_W-1:0] ang_o,
  output logic [SIDE_W-1:0]       side_o
);

  localparam int unsigned DATA_W = 2 * DW + ANG_W + SIDE_W;

  logic signed [DW-1:0]    dx;
  logic signed [DW-1:0]    dy;
  logic signed [DW-1:0]    x_d;
  logic signed [DW-1:0]    y_d;
  logic signed [ANG_W-1:0] step_ang;
  logic signed [ANG_W-1:0] ang_d;
  logic [DATA_W-1:0]       data_out;

  // arithmetic shifts floor toward minus infinity
  assign dx       = y_i >>> STEP;
  assign dy       = x_i >>> STEP;
  assign step_ang = $signed({{(ANG_W - ATAN_W){1'b0}}, ATAN_TABLE[STEP]});

  // rotate toward y = 0
  always_comb begin
    if (!y_i[DW-1]) begin
      x_d   = x_i + dx;
      y_d   = y_i - dy;
      ang_d = ang_i + step_ang;
    end else begin
      x_d   = x_i - dx;
      y_d   = y_i + dy;
      ang_d = ang_i - step_ang;
    end
  end

  c2s_pipe_reg #(
    .WIDTH(DATA_W)
  ) u_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(valid_i),
    .ready_o(ready_o),
    .data_i ({x_d, y_d, ang_d, side_i}),
    .valid_o(valid_o),
    .ready_i(ready_i),
    .data_o (data_out)
  );

  assign {x_o, y_o, ang_o, side_o} = data_out;

endmodule

FILE: rtl/core/cartesian_to_spherical.sv
// Cartesian to spherical conversion: radius, polar angle and azimuth of a 3-D point.
// Depth: COORD_WIDTH + 2*CORDIC_STEPS + 7 register stages (59 at the defaults).
// Throughput: one request per cycle while the output is not stalled; every stage is an elastic register, so a
//   bubble anywhere is filled while the output stalls.
// The depth comes from one stage per root digit and one per CORDIC rotation.
// Reset (rst_ni low, asynchronous) empties the pipeline; data registers keep no reset.
module cartesian_to_spherical
  import c2s_pkg::*;
#(
  parameter int unsigned COORD_WIDTH  = COORD_WIDTH_DEF,
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // slave side
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: coord_x, coord_y, coord_z (signed, COORD_WIDTH each), zero pad
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
  // master side
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata: radius[15:0], polar_angle[30:16], azimuth_angle[46:31] (signed), zero pad
  output logic [OUT_TDATA_W-1:0]               m_axis_tdata,
  // tuser: zero_vector
  output logic                                 m_axis_tuser
);

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned S     = CORDIC_STEPS;
  // CORDIC datapath: scaled coordinate plus headroom for gain and the 3-D length
  localparam int unsigned DW    = CW + GUARD_BITS + 3;
  localparam int unsigned EXT_W = DW - CW - GUARD_BITS;
  localparam int unsigned PW    = CW + GAIN_W;

  // sideband carried through each section
  localparam int unsigned SQ_SIDE_W = 3 * CW + 2;              // z, y, x, xy_zero, zero
  localparam int unsigned AZ_SIDE_W = DW + RADIUS_W + 2;       // pz, radius, xy_zero, zero
  localparam int unsigned PO_SIDE_W = ANG_W + RADIUS_W + 2;    // az angle, radius, flags

  localparam int unsigned R0_W = 3 * CW;
  localparam int unsigned R1_W = 6 * CW + SQ_SIDE_W;
  localparam int unsigned R2_W = 2 * CW + SQ_SIDE_W;
  localparam int unsigned R3_W = 2 * DW + ANG_W + AZ_SIDE_W;
  localparam int unsigned R4_W = 2 * DW + ANG_W + PO_SIDE_W;
  localparam int unsigned R5_W = 2 * PROD_W + 2 + RADIUS_W + 2;
  localparam int unsigned R6_W = OUT_TDATA_W + 1;

  localparam int unsigned RF_W = CW + 1;
  localparam int unsigned RC_W = (RF_W > RADIUS_W) ? RF_W : RADIUS_W;

  // ---------------------------------------------------------------------------
  // Stage 0: input register
  // ---------------------------------------------------------------------------
  logic            r0_valid, r1_ready;
  logic [R0_W-1:0] r0_data;

  c2s_pipe_reg #(
    .WIDTH(R0_W)
  ) u_in_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s_axis_tvalid),
    .ready_o(s_axis_tready),
    .data_i (s_axis_tdata[R0_W-1:0]),
    .valid_o(r0_valid),
    .ready_i(r1_ready),
    .data_o (r0_data)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: magnitudes squared, special-case flags
  // ---------------------------------------------------------------------------
  logic [CW-1:0]   in_x, in_y, in_z;
  logic [CW-1:0]   abs_x, abs_y, abs_z;
  logic [2*CW-1:0] sq_x, sq_y, sq_z;
  logic            in_xy_zero, in_zero;

  assign {in_z, in_y, in_x} = r0_data;

  assign abs_x = in_x[CW-1] ? (~in_x + 1'b1) : in_x;
  assign abs_y = in_y[CW-1] ? (~in_y + 1'b1) : in_y;
  assign abs_z = in_z[CW-1] ? (~in_z + 1'b1) : in_z;

  assign sq_x = abs_x * abs_x;
  assign sq_y = abs_y * abs_y;
  assign sq_z = abs_z * abs_z;

  assign in_xy_zero = (in_x == '0) && (in_y == '0);
  assign in_zero    = in_xy_zero && (in_z == '0);

  logic            r1_valid, r2_ready;
  logic [R1_W-1:0] r1_data;

  c2s_pipe_reg #(
    .WIDTH(R1_W)
  ) u_sq_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(r0_valid),
    .ready_o(r1_ready),
    .data_i ({sq_z, sq_y, sq_x, in_z, in_y, in_x, in_xy_zero, in_zero}),
    .valid_o(r1_valid),
    .ready_i(r2_ready),
    .data_o (r1_data)
  );

  // ---------------------------------------------------------------------------
  // Stage 2: sum of squares (below 2^(2*CW), no carry out)
  // ---------------------------------------------------------------------------
  logic [2*CW-1:0]      r1_sq_x, r1_sq_y, r1_sq_z, sum_sq;
  logic [SQ_SIDE_W-1:0] r1_side;

  assign {r1_sq_z, r1_sq_y, r1_sq_x, r1_side} = r1_data;
  assign sum_sq = r1_sq_x + r1_sq_y + r1_sq_z;

  logic            r2_valid;
  logic [R2_W-1:0] r2_data;
  logic [CW:0]     sq_valid;
  logic [CW:0]     sq_ready;

  c2s_pipe_reg #(
    .WIDTH(R2_W)
  ) u_sum_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(r1_valid),
    .ready_o(r2_ready),
    .data_i ({sum_sq, r1_side}),
    .valid_o(r2_valid),
    .ready_i(sq_ready[0]),
    .data_o (r2_data)
  );

  // ---------------------------------------------------------------------------
  // Square root: one digit per stage, most significant first
  // ---------------------------------------------------------------------------
  logic [2*CW-1:0]      sq_rem  [CW+1];
  logic [CW-1:0]        sq_root [CW+1];
  logic [SQ_SIDE_W-1:0] sq_side [CW+1];

  assign sq_valid[0]              = r2_valid;
  assign {sq_rem[0], sq_side[0]}  = r2_data;
  assign sq_root[0]               = '0;

  for (genvar j = 0; j < CW; j++) begin : g_sqrt
    c2s_sqrt_stage #(
      .CW    (CW),
      .DIGIT (CW - 1 - j),
      .SIDE_W(SQ_SIDE_W)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(sq_valid[j]),
      .ready_o(sq_ready[j]),
      .rem_i  (sq_rem[j]),
      .root_i (sq_root[j]),
      .side_i (sq_side[j]),
      .valid_o(sq_valid[j+1]),
      .ready_i(sq_ready[j+1]),
      .rem_o  (sq_rem[j+1]),
      .root_o (sq_root[j+1]),
      .side_o (sq_side[j+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Stage 3: round the root, set up the azimuth rotation, pre-scale z by gain
  // ---------------------------------------------------------------------------
  logic [CW-1:0]        sr_x, sr_y, sr_z;
  logic                 sr_xy_zero, sr_zero;
  logic                 round_up;
  logic [RF_W-1:0]      rad_full;
  logic [RC_W-1:0]      rad_wide;
  logic [RADIUS_W-1:0]  radius;

  assign {sr_z, sr_y, sr_x, sr_xy_zero, sr_zero} = sq_side[CW];

  // remainder beyond the root means the true root lies past the half
  assign round_up = sq_rem[CW] > {{CW{1'b0}}, sq_root[CW]};
  assign rad_full = {1'b0, sq_root[CW]} + RF_W'(round_up);
  assign rad_wide = RC_W'(rad_full);
  assign radius   = (rad_wide > RC_W'(RADIUS_MAX)) ? RADIUS_MAX : rad_wide[RADIUS_W-1:0];

  logic signed [DW-1:0]    cx, cy, az_x0, az_y0;
  logic signed [ANG_W-1:0] az_ang0;
  logic signed [CW-1:0]    z_s;
  logic signed [PW-1:0]    z_gain, z_gain_sh;
  logic signed [DW-1:0]    pz;

  assign cx = {{EXT_W{sr_x[CW-1]}}, sr_x, {GUARD_BITS{1'b0}}};
  assign cy = {{EXT_W{sr_y[CW-1]}}, sr_y, {GUARD_BITS{1'b0}}};

  // left half plane: turn the vector by 180 deg first
  always_comb begin
    if (cx[DW-1]) begin
      az_x0   = -cx;
      az_y0   = -cy;
      az_ang0 = cy[DW-1] ? NEG_HALF_TURN : HALF_TURN;
    end else begin
      az_x0   = cx;
      az_y0   = cy;
      az_ang0 = '0;
    end
  end

  assign z_s       = sr_z;
  assign z_gain    = z_s * GAIN_Q30;
  assign z_gain_sh = z_gain >>> GAIN_SHIFT;
  assign pz        = z_gain_sh[DW-1:0];

  logic            r3_valid;
  logic [R3_W-1:0] r3_data;
  logic [S:0]      az_valid;
  logic [S:0]      az_ready;

  c2s_pipe_reg #(
    .WIDTH(R3_W)
  ) u_az_setup_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(sq_valid[CW]),
    .ready_o(sq_ready[CW]),
    .data_i ({az_x0, az_y0, az_ang0, pz, radius, sr_xy_zero, sr_zero}),
    .valid_o(r3_valid),
    .ready_i(az_ready[0]),
    .data_o (r3_data)
  );

  // ---------------------------------------------------------------------------
  // Azimuth CORDIC: atan2(y, x); x converges to the gain-scaled planar length
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0]    az_x   [S+1];
  logic signed [DW-1:0]    az_y   [S+1];
  logic signed [ANG_W-1:0] az_ang [S+1];
  logic [AZ_SIDE_W-1:0]    az_side[S+1];

  assign az_valid[0] = r3_valid;
  assign {az_x[0], az_y[0], az_ang[0], az_side[0]} = r3_data;

  for (genvar i = 0; i < S; i++) begin : g_azim
    c2s_cordic_stage #(
      .DW    (DW),
      .STEP  (i),
      .SIDE_W(AZ_SIDE_W)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(az_valid[i]),
      .ready_o(az_ready[i]),
      .x_i    (az_x[i]),
      .y_i    (az_y[i]),
      .ang_i  (az_ang[i]),
      .side_i (az_side[i]),
      .valid_o(az_valid[i+1]),
      .ready_i(az_ready[i+1]),
      .x_o    (az_x[i+1]),
      .y_o    (az_y[i+1]),
      .ang_o  (az_ang[i+1]),
      .side_o (az_side[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Stage 4: polar rotation setup, vector (gain*z, rho)
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0]    ae_pz, rho;
  logic [RADIUS_W-1:0]     ae_radius;
  logic                    ae_xy_zero, ae_zero;
  logic signed [DW-1:0]    po_x0, po_y0;
  logic signed [ANG_W-1:0] po_ang0;

  assign {ae_pz, ae_radius, ae_xy_zero, ae_zero} = az_side[S];
  // on the z axis the rotation sees (0, 0) and rho stays zero
  assign rho = az_x[S];

  always_comb begin
    if (ae_pz[DW-1]) begin
      po_x0   = -ae_pz;
      po_y0   = -rho;
      po_ang0 = rho[DW-1] ? NEG_HALF_TURN : HALF_TURN;
    end else begin
      po_x0   = ae_pz;
      po_y0   = rho;
      po_ang0 = '0;
    end
  end

  logic            r4_valid;
  logic [R4_W-1:0] r4_data;
  logic [S:0]      po_valid;
  logic [S:0]      po_ready;

  c2s_pipe_reg #(
    .WIDTH(R4_W)
  ) u_po_setup_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(az_valid[S]),
    .ready_o(az_ready[S]),
    .data_i ({po_x0, po_y0, po_ang0, az_ang[S], ae_radius, ae_xy_zero, ae_zero}),
    .valid_o(r4_valid),
    .ready_i(po_ready[0]),
    .data_o (r4_data)
  );

  // ---------------------------------------------------------------------------
  // Polar CORDIC: atan2(rho, z) = acos(z / r)
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0]    po_x   [S+1];
  logic signed [DW-1:0]    po_y   [S+1];
  logic signed [ANG_W-1:0] po_ang [S+1];
  logic [PO_SIDE_W-1:0]    po_side[S+1];

  assign po_valid[0] = r4_valid;
  assign {po_x[0], po_y[0], po_ang[0], po_side[0]} = r4_data;

  for (genvar i = 0; i < S; i++) begin : g_polar
    c2s_cordic_stage #(
      .DW    (DW),
      .STEP  (i),
      .SIDE_W(PO_SIDE_W)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(po_valid[i]),
      .ready_o(po_ready[i]),
      .x_i    (po_x[i]),
      .y_i    (po_y[i]),
      .ang_i  (po_ang[i]),
      .side_i (po_side[i]),
      .valid_o(po_valid[i+1]),
      .ready_i(po_ready[i+1]),
      .x_o    (po_x[i+1]),
      .y_o    (po_y[i+1]),
      .ang_o  (po_ang[i+1]),
      .side_o (po_side[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Stage 5: angle magnitudes times 360*128
  // ---------------------------------------------------------------------------
  logic signed [ANG_W-1:0] pe_az_ang, pol_abs, az_abs;
  logic [RADIUS_W-1:0]     pe_radius;
  logic                    pe_xy_zero, pe_zero;
  logic                    pol_neg, az_neg;
  logic [MAG_W-1:0]        pol_mag, az_mag;
  logic [PROD_W-1:0]       pol_prod, az_prod;

  assign {pe_az_ang, pe_radius, pe_xy_zero, pe_zero} = po_side[S];

  assign pol_neg = po_ang[S][ANG_W-1];
  assign az_neg  = pe_az_ang[ANG_W-1];
  assign pol_abs = pol_neg ? -po_ang[S] : po_ang[S];
  assign az_abs  = az_neg ? -pe_az_ang : pe_az_ang;
  assign pol_mag = pol_abs[MAG_W-1:0];
  assign az_mag  = az_abs[MAG_W-1:0];

  assign pol_prod = pol_mag * DEG_SCALE;
  assign az_prod  = az_mag * DEG_SCALE;

  logic            r5_valid, r6_ready;
  logic [R5_W-1:0] r5_data;

  c2s_pipe_reg #(
    .WIDTH(R5_W)
  ) u_scale_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(po_valid[S]),
    .ready_o(po_ready[S]),
    .data_i ({pol_prod, pol_neg, az_prod, az_neg, pe_radius, pe_xy_zero, pe_zero}),
    .valid_o(r5_valid),
    .ready_i(r6_ready),
    .data_o (r5_data)
  );

  // ---------------------------------------------------------------------------
  // Stage 6: round half away from zero, clamp, apply special cases; output register
  // ---------------------------------------------------------------------------
  logic [PROD_W-1:0]    f_pol_prod, f_az_prod, pol_rnd, az_rnd;
  logic                 f_pol_neg, f_az_neg;
  logic [RADIUS_W-1:0]  f_radius;
  logic                 f_xy_zero, f_zero;
  logic [ANGLE_Q_W-1:0] pol_q, az_q, pol_clamp, az_clamp, az_signed;
  logic [POLAR_W-1:0]   polar_angle;
  logic [AZIM_W-1:0]    azimuth_angle;

  assign {f_pol_prod, f_pol_neg, f_az_prod, f_az_neg, f_radius, f_xy_zero, f_zero} = r5_data;

  assign pol_rnd = f_pol_prod + ROUND_HALF;
  assign az_rnd  = f_az_prod + ROUND_HALF;
  assign pol_q   = pol_rnd[PROD_W-1 -: ANGLE_Q_W];
  assign az_q    = az_rnd[PROD_W-1 -: ANGLE_Q_W];

  assign pol_clamp = (pol_q > ANGLE_LIMIT) ? ANGLE_LIMIT : pol_q;
  assign az_clamp  = (az_q > ANGLE_LIMIT) ? ANGLE_LIMIT : az_q;
  assign az_signed = f_az_neg ? (~az_clamp + 1'b1) : az_clamp;

  // polar below zero clamps to zero; zero vector forces both angles to zero
  assign polar_angle   = (f_zero || f_pol_neg) ? '0 : pol_clamp[POLAR_W-1:0];
  // on the z axis the azimuth rotation ran on nothing
  assign azimuth_angle = (f_zero || f_xy_zero) ? '0 : az_signed[AZIM_W-1:0];

  logic [R6_W-1:0] r6_data;

  c2s_pipe_reg #(
    .WIDTH(R6_W)
  ) u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(r5_valid),
    .ready_o(r6_ready),
    .data_i ({f_zero, {OUT_PAD_W{1'b0}}, azimuth_angle, polar_angle, f_radius}),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .data_o (r6_data)
  );

  assign {m_axis_tuser, m_axis_tdata} = r6_data;

endmodule
